@@ design/bds_pkg.sv @@
`timescale 1ns / 1ps
package bds_pkg;

  localparam int CFG_DW       = 13;
  localparam int ROW_W        = 12;
  localparam int COORD_W      = 11;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [CFG_DW-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DW-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_DW-1:0] HEIGHT_CAP   = 13'd4096;

  localparam logic CFG_IN_WIDTH  = 1'b0;
  localparam logic CFG_IN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_STORE,
    KIND_EMIT_LINE,
    KIND_EMIT_DOUBLE
  } bds_kind_e;

  typedef logic [3:0][7:0] bds_pix_t;
  typedef logic [3:0][8:0] bds_pair_t;

  typedef struct packed {
    logic [CFG_DW-1:0] width;
    logic [CFG_DW-1:0] height;
    logic              restart;
  } bds_cfg_t;

  typedef struct packed {
    bds_kind_e          kind;
    bds_pair_t          pair;
    logic [COORD_W-1:0] y;
    logic               last;
  } bds_item_t;

endpackage

@@ design/bds_in_if.sv @@
`timescale 1ns / 1ps
interface bds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

@@ design/bds_out_if.sv @@
`timescale 1ns / 1ps
interface bds_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  alpha_out;
  logic [10:0] out_column;
  logic [10:0] out_row;
  logic        frame_last;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out, out_column, out_row, frame_last,
    input ready
  );
  modport sink (
    input valid, red_out, green_out, blue_out, alpha_out, out_column, out_row, frame_last,
    output ready
  );
endinterface

@@ design/bds_front.sv @@
`timescale 1ns / 1ps
module bds_front import bds_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bds_cfg_t    cfg_i,
  bds_in_if.sink      pix_in,
  input  logic        q_ready_i,
  output logic        push_o,
  output logic [((MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] push_x_o,
  output bds_item_t   push_item_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1;

  logic [CW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  bds_pix_t          held_q;
  bds_pix_t          pix;
  bds_pix_t          first;
  logic [WW-1:0]     w_eff, half_w;
  logic [CFG_DW-1:0] h_eff, half_h;
  logic [XW-1:0]     x, ow_m1;
  logic [COORD_W-1:0] y, oh_m1;
  logic              fire, width_one, height_one, col_last, row_last;

  always_comb begin
    if (cfg_i.width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_i.width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_i.width);
    end
    if (cfg_i.height == '0) begin
      h_eff = CFG_DW'(1);
    end else if (cfg_i.height > HEIGHT_CAP) begin
      h_eff = HEIGHT_CAP;
    end else begin
      h_eff = cfg_i.height;
    end
  end

  assign pix        = {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in, pix_in.red_in};
  assign fire       = pix_in.valid && pix_in.ready;
  assign pix_in.ready = q_ready_i;
  assign width_one  = (w_eff == WW'(1));
  assign height_one = (h_eff == CFG_DW'(1));
  assign col_last   = (32'(col_q) + 32'd1) >= 32'(w_eff);
  assign row_last   = (32'(row_q) + 32'd1) >= 32'(h_eff);
  assign half_w     = w_eff >> 1;
  assign half_h     = h_eff >> 1;
  assign ow_m1      = (half_w == '0) ? '0 : XW'(half_w - WW'(1));
  assign oh_m1      = (half_h == '0) ? '0 : COORD_W'(half_h - CFG_DW'(1));
  assign x          = width_one ? '0 : XW'(col_q >> 1);
  assign y          = height_one ? '0 : COORD_W'(row_q >> 1);
  assign first      = width_one ? pix : held_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      push_item_o.pair[k] = {1'b0, first[k]} + {1'b0, pix[k]};
    end
    if (height_one) begin
      push_item_o.kind = KIND_EMIT_DOUBLE;
    end else if (row_q[0]) begin
      push_item_o.kind = KIND_EMIT_LINE;
    end else begin
      push_item_o.kind = KIND_STORE;
    end
    push_item_o.y    = y;
    push_item_o.last = (x == ow_m1) && (y == oh_m1);
  end

  assign push_x_o = x;
  assign push_o   = fire && (width_one || col_q[0]);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_i.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (fire) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !col_q[0]) begin
      held_q <= pix;
    end
  end

endmodule

@@ design/bds_queue.sv @@
`timescale 1ns / 1ps
module bds_queue import bds_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != NW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + NW'(push_i) - NW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ design/bds_back.sv @@
`timescale 1ns / 1ps
module bds_back import bds_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  logic [((MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] q_x_i,
  input  bds_item_t q_item_i,
  output logic      pop_o,
  bds_out_if.source pix_out
);

  localparam int XW = (MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int LD = MAX_WIDTH / 2;

  bds_pair_t      line_mem [LD];
  bds_pair_t      rdata_q;
  bds_pair_t      pair_q;
  bds_kind_e      kind_q;
  logic [XW-1:0]  x_q;
  logic [COORD_W-1:0] y_q;
  logic           last_q;
  logic           s2_valid_q, s2_valid_d;
  logic [9:0]     sum [4];

  assign pop_o = q_valid_i && (!s2_valid_q || pix_out.ready);

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (pop_o) begin
      s2_valid_d = (q_item_i.kind != KIND_STORE);
    end else if (pix_out.ready) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_item_i.kind == KIND_STORE) begin
      line_mem[q_x_i] <= q_item_i.pair;
    end
    if (pop_o && q_item_i.kind == KIND_EMIT_LINE) begin
      rdata_q <= line_mem[q_x_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_item_i.kind != KIND_STORE) begin
      pair_q <= q_item_i.pair;
      kind_q <= q_item_i.kind;
      x_q    <= q_x_i;
      y_q    <= q_item_i.y;
      last_q <= q_item_i.last;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = {1'b0, pair_q[k]} +
               {1'b0, ((kind_q == KIND_EMIT_LINE) ? rdata_q[k] : pair_q[k])};
    end
  end

  assign pix_out.valid      = s2_valid_q;
  assign pix_out.red_out    = sum[0][9:2];
  assign pix_out.green_out  = sum[1][9:2];
  assign pix_out.blue_out   = sum[2][9:2];
  assign pix_out.alpha_out  = sum[3][9:2];
  assign pix_out.out_column = COORD_W'(x_q);
  assign pix_out.out_row    = y_q;
  assign pix_out.frame_last = last_q;

endmodule

@@ design/box_downsample_2x2_rgba.sv @@
`timescale 1ns / 1ps
// Channel    Dir  Payload
// pix_in     in   red_in, green_in, blue_in, alpha_in
// pix_out    out  RGBA average, out_column, out_row, frame_last
// cfg        in   cfg_idx_i selects in_width or in_height, cfg_data_i
//
// One pixel request is taken every cycle while the four-entry queue has room.
// A result passes through a queue slot and then the output stage, which also holds
// the registered line memory read.
// Reset clears the counters, the queue and the output stage; no memory clearing.
// A stalled output holds the back end, and the front keeps going until the queue fills.
module box_downsample_2x2_rgba import bds_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bds_in_if.sink            pix_in,
  bds_out_if.source         pix_out,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int XW = (MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int QW = XW + $bits(bds_item_t);

  logic [CFG_DW-1:0] width_q, height_q;
  bds_cfg_t          cfg;
  logic              q_push, q_ready, q_pop, q_valid;
  logic [XW-1:0]     push_x;
  bds_item_t         push_item;
  logic [QW-1:0]     q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IN_WIDTH:  width_q  <= cfg_data_i;
        CFG_IN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.width   = width_q;
  assign cfg.height  = height_q;
  assign cfg.restart = cfg_we_i;

  bds_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pix_in      (pix_in),
    .q_ready_i   (q_ready),
    .push_o      (q_push),
    .push_x_o    (push_x),
    .push_item_o (push_item)
  );

  bds_queue #(.DW(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({push_x, push_item}),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  bds_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_x_i     (q_data[QW-1 -: XW]),
    .q_item_i  (bds_item_t'(q_data[$bits(bds_item_t)-1:0])),
    .pop_o     (q_pop),
    .pix_out   (pix_out)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> q_ready)
    else $error("queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("queue read while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_out.valid && !pix_out.ready) |-> !q_pop)
    else $error("back end advanced under a stalled output");

endmodule
